### design/cdb_pkg.sv
package cdb_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned RawDayW = 6;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;

  localparam logic [YearW-1:0] MaxYear = 14'd9999;

  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned QuotW = 8;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef enum logic [3:0] {
    StIdle,
    StNorm0,
    StNorm1,
    StNorm2,
    StNorm3,
    StOrder,
    StWalk,
    StLeap0,
    StLeap1,
    StLeap2
  } state_e;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month)
      MonthFeb: len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### design/cdb_leap.sv
module cdb_leap (
  input  logic                          clk_i,
  input  logic [cdb_pkg::YearW-1:0]     year_i,
  output logic                          leap_o
);

  logic [cdb_pkg::YearW+12:0]    prod;
  logic [cdb_pkg::YearW-1:0]     year_q;
  logic [cdb_pkg::QuotW-1:0]     quot_q;
  logic [cdb_pkg::QuotW+6:0]     hundreds;
  logic                          div100;
  logic                          leap_d;
  logic                          leap_q;

  assign prod = year_i * cdb_pkg::Recip100;

  always_ff @(posedge clk_i) begin
    year_q <= year_i;
    quot_q <= prod[cdb_pkg::RecipShift +: cdb_pkg::QuotW];
  end

  always_comb begin
    hundreds = quot_q * 7'd100;
    div100   = (hundreds == {1'b0, year_q});
    leap_d   = (year_q[1:0] == 2'b00) && (!div100 || (quot_q[1:0] == 2'b00));
  end

  always_ff @(posedge clk_i) begin
    leap_q <= leap_d;
  end

  assign leap_o = leap_q;

endmodule

### design/cdb_step.sv
module cdb_step (
  input  cdb_pkg::date_t date_i,
  input  logic           leap_i,
  output cdb_pkg::date_t date_o,
  output logic           year_wrap_o
);

  logic [cdb_pkg::DayW-1:0] len;

  always_comb begin
    len         = cdb_pkg::month_len(date_i.month, leap_i);
    date_o      = date_i;
    year_wrap_o = 1'b0;
    if (date_i.day < len) begin
      date_o.day = date_i.day + 5'd1;
    end else begin
      date_o.day = 5'd1;
      if (date_i.month < cdb_pkg::MonthDec) begin
        date_o.month = date_i.month + 4'd1;
      end else begin
        date_o.month = cdb_pkg::MonthJan;
        date_o.year  = date_i.year + 14'd1;
        year_wrap_o  = 1'b1;
      end
    end
  end

endmodule

### design/calendar_days_between_core.sv
// Counts the days between two Gregorian dates. Each day is clamped into the
// length of its month (month codes outside 1 to 12 clamp to January or
// December, years above MaxYear saturate), the dates are ordered, and the
// earlier one is stepped forward one day per cycle, pausing for the leap check
// at each year boundary crossed, until it meets the later one. Setup states
// clamp the days and order the dates before the walk, and a single date
// stepper advances it. The count saturates at the 22-bit maximum. The result
// sits in an output register, so a new request can be taken while the last
// result waits.
module calendar_days_between_core #(
  parameter logic [cdb_pkg::YearW-1:0] MaxYear = cdb_pkg::MaxYear
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cdb_pkg::YearW-1:0]       first_year_i,
  input  logic [cdb_pkg::MonthW-1:0]      first_month_i,
  input  logic [cdb_pkg::RawDayW-1:0]     first_day_i,
  input  logic [cdb_pkg::YearW-1:0]       second_year_i,
  input  logic [cdb_pkg::MonthW-1:0]      second_month_i,
  input  logic [cdb_pkg::RawDayW-1:0]     second_day_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cdb_pkg::CountW-1:0]      day_count_o
);

  cdb_pkg::state_e state_q, state_d;

  logic [cdb_pkg::YearW-1:0]   a_year_q, a_year_d, b_year_q, b_year_d;
  logic [cdb_pkg::MonthW-1:0]  a_month_q, a_month_d, b_month_q, b_month_d;
  logic [cdb_pkg::RawDayW-1:0] a_day_q, a_day_d, b_day_q, b_day_d;
  logic                        a_leap_q, a_leap_d, b_leap_q, b_leap_d;

  cdb_pkg::date_t              walk_q, walk_d, goal_q, goal_d;
  logic                        walk_leap_q, walk_leap_d;
  logic [cdb_pkg::CountW-1:0]  count_q, count_d;

  logic                        out_valid_q, out_valid_d;
  logic [cdb_pkg::CountW-1:0]  out_count_q, out_count_d;

  logic [cdb_pkg::YearW-1:0]   leap_year;
  logic                        leap;
  cdb_pkg::date_t              next_date;
  logic                        year_wrap;
  cdb_pkg::date_t              a_date, b_date;

  cdb_leap u_leap (
    .clk_i  (clk_i),
    .year_i (leap_year),
    .leap_o (leap)
  );

  cdb_step u_step (
    .date_i      (walk_q),
    .leap_i      (walk_leap_q),
    .date_o      (next_date),
    .year_wrap_o (year_wrap)
  );

  function automatic logic [cdb_pkg::MonthW-1:0] clamp_month(
    input logic [cdb_pkg::MonthW-1:0] month);
    logic [cdb_pkg::MonthW-1:0] m;
    m = month;
    if (month == 4'd0) begin
      m = cdb_pkg::MonthJan;
    end else if (month > cdb_pkg::MonthDec) begin
      m = cdb_pkg::MonthDec;
    end
    return m;
  endfunction

  function automatic logic [cdb_pkg::RawDayW-1:0] clamp_day(
    input logic [cdb_pkg::RawDayW-1:0] day,
    input logic [cdb_pkg::MonthW-1:0]  month,
    input logic                        leap_in);
    logic [cdb_pkg::DayW-1:0]    len;
    logic [cdb_pkg::RawDayW-1:0] d;
    len = cdb_pkg::month_len(month, leap_in);
    d   = day;
    if (day > {1'b0, len}) begin
      d = {1'b0, len};
    end else if (day == 6'd0) begin
      d = 6'd1;
    end
    return d;
  endfunction

  assign a_date = '{year: a_year_q, month: a_month_q, day: a_day_q[cdb_pkg::DayW-1:0]};
  assign b_date = '{year: b_year_q, month: b_month_q, day: b_day_q[cdb_pkg::DayW-1:0]};

  always_comb begin
    unique case (state_q)
      cdb_pkg::StNorm0: leap_year = a_year_q;
      cdb_pkg::StNorm1: leap_year = b_year_q;
      default:          leap_year = walk_q.year;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    a_year_d    = a_year_q;
    a_month_d   = a_month_q;
    a_day_d     = a_day_q;
    a_leap_d    = a_leap_q;
    b_year_d    = b_year_q;
    b_month_d   = b_month_q;
    b_day_d     = b_day_q;
    b_leap_d    = b_leap_q;
    walk_d      = walk_q;
    goal_d      = goal_q;
    walk_leap_d = walk_leap_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      cdb_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          a_year_d  = (first_year_i > MaxYear) ? MaxYear : first_year_i;
          a_month_d = clamp_month(first_month_i);
          a_day_d   = first_day_i;
          b_year_d  = (second_year_i > MaxYear) ? MaxYear : second_year_i;
          b_month_d = clamp_month(second_month_i);
          b_day_d   = second_day_i;
          state_d   = cdb_pkg::StNorm0;
        end
      end
      cdb_pkg::StNorm0: state_d = cdb_pkg::StNorm1;
      cdb_pkg::StNorm1: state_d = cdb_pkg::StNorm2;
      cdb_pkg::StNorm2: begin
        a_leap_d = leap;
        a_day_d  = clamp_day(a_day_q, a_month_q, leap);
        state_d  = cdb_pkg::StNorm3;
      end
      cdb_pkg::StNorm3: begin
        b_leap_d = leap;
        b_day_d  = clamp_day(b_day_q, b_month_q, leap);
        state_d  = cdb_pkg::StOrder;
      end
      cdb_pkg::StOrder: begin
        count_d = '0;
        if (a_date > b_date) begin
          walk_d      = b_date;
          walk_leap_d = b_leap_q;
          goal_d      = a_date;
        end else begin
          walk_d      = a_date;
          walk_leap_d = a_leap_q;
          goal_d      = b_date;
        end
        state_d = cdb_pkg::StWalk;
      end
      cdb_pkg::StWalk: begin
        if (walk_q == goal_q) begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_d = 1'b1;
            out_count_d = count_q;
            state_d     = cdb_pkg::StIdle;
          end
        end else begin
          walk_d = next_date;
          if (count_q != '1) begin
            count_d = count_q + 22'd1;
          end
          if (year_wrap) begin
            state_d = cdb_pkg::StLeap0;
          end
        end
      end
      cdb_pkg::StLeap0: state_d = cdb_pkg::StLeap1;
      cdb_pkg::StLeap1: state_d = cdb_pkg::StLeap2;
      cdb_pkg::StLeap2: begin
        walk_leap_d = leap;
        state_d     = cdb_pkg::StWalk;
      end
      default: state_d = cdb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdb_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_year_q    <= a_year_d;
    a_month_q   <= a_month_d;
    a_day_q     <= a_day_d;
    a_leap_q    <= a_leap_d;
    b_year_q    <= b_year_d;
    b_month_q   <= b_month_d;
    b_day_q     <= b_day_d;
    b_leap_q    <= b_leap_d;
    walk_q      <= walk_d;
    goal_q      <= goal_d;
    walk_leap_q <= walk_leap_d;
    count_q     <= count_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign day_count_o = out_count_q;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned YearW = cdb_pkg::YearW;
  localparam int unsigned MonthW = cdb_pkg::MonthW;
  localparam int unsigned RawDayW = cdb_pkg::RawDayW;
  localparam int unsigned DayW = cdb_pkg::DayW;
  localparam int unsigned CountW = cdb_pkg::CountW;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned IdlePct = 29;
  localparam int unsigned RandomRequests = 80;
  localparam int unsigned RxHoldCycles = 4000;
  localparam int unsigned YearSpan = 16383;

  typedef struct {
    logic [YearW-1:0]   first_year;
    logic [MonthW-1:0]  first_month;
    logic [RawDayW-1:0] first_day;
    logic [YearW-1:0]   second_year;
    logic [MonthW-1:0]  second_month;
    logic [RawDayW-1:0] second_day;
    bit                 wait_idle;
  } date_pair_t;

  logic clk;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic [YearW-1:0]   first_year = '0;
  logic [MonthW-1:0]  first_month = '0;
  logic [RawDayW-1:0] first_day = '0;
  logic [YearW-1:0]   second_year = '0;
  logic [MonthW-1:0]  second_month = '0;
  logic [RawDayW-1:0] second_day = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic [CountW-1:0]  day_count_o;

  date_pair_t        date_pair_q[$];
  logic [CountW-1:0] day_count_q[$];

  bit          req_accepted = 1'b0;
  bit          failed = 1'b0;
  bit          rx_hold_done = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  calendar_days_between_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .first_year_i   (first_year),
    .first_month_i  (first_month),
    .first_day_i    (first_day),
    .second_year_i  (second_year),
    .second_month_i (second_month),
    .second_day_i   (second_day),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .day_count_o    (day_count_o)
  );

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, logic [MonthW-1:0] m);
    if (m == cdb_pkg::MonthFeb) return leap_year(y) ? 29 : 28;
    if (m == cdb_pkg::MonthApr || m == cdb_pkg::MonthJun ||
        m == cdb_pkg::MonthSep || m == cdb_pkg::MonthNov) return 30;
    return 31;
  endfunction

  function automatic cdb_pkg::date_t clamp_date(logic [YearW-1:0] y, logic [MonthW-1:0] m,
                                                logic [RawDayW-1:0] d);
    cdb_pkg::date_t r;
    int unsigned    len;
    r.year = (y > cdb_pkg::MaxYear) ? cdb_pkg::MaxYear : y;
    if (m < cdb_pkg::MonthJan) begin
      r.month = cdb_pkg::MonthJan;
    end else if (m > cdb_pkg::MonthDec) begin
      r.month = cdb_pkg::MonthDec;
    end else begin
      r.month = m;
    end
    len = month_length(r.year, r.month);
    if (d > len) begin
      r.day = DayW'(len);
    end else if (d == 0) begin
      r.day = DayW'(1);
    end else begin
      r.day = DayW'(d);
    end
    return r;
  endfunction

  function automatic int unsigned day_number(cdb_pkg::date_t t);
    int unsigned y;
    int unsigned n;
    y = t.year;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + t.day - 1;
    for (int k = int'(cdb_pkg::MonthJan); k < int'(t.month); k++) begin
      n += month_length(y, MonthW'(k));
    end
    return n;
  endfunction

  function automatic logic [CountW-1:0] days_between(date_pair_t p);
    int unsigned na;
    int unsigned nb;
    int unsigned diff;
    na = day_number(clamp_date(p.first_year, p.first_month, p.first_day));
    nb = day_number(clamp_date(p.second_year, p.second_month, p.second_day));
    diff = (na > nb) ? na - nb : nb - na;
    if (diff > (2 ** CountW - 1)) return '1;
    return CountW'(diff);
  endfunction

  task automatic queue_dates(int unsigned y1, int unsigned m1, int unsigned d1,
                             int unsigned y2, int unsigned m2, int unsigned d2,
                             bit wait_idle = 1'b0);
    date_pair_t p;
    p.first_year = YearW'(y1);
    p.first_month = MonthW'(m1);
    p.first_day = RawDayW'(d1);
    p.second_year = YearW'(y2);
    p.second_month = MonthW'(m2);
    p.second_day = RawDayW'(d2);
    p.wait_idle = wait_idle;
    date_pair_q.push_back(p);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender
  always @(negedge clk) begin
    if (rst_ni && (!in_valid || req_accepted)) begin
      if (date_pair_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (date_pair_q[0].wait_idle && day_count_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (!(requests_taken >= 50 && requests_taken < 75) &&
                   $urandom_range(0, 99) < IdlePct) begin
        in_valid <= 1'b0;
      end else begin
        first_year <= date_pair_q[0].first_year;
        first_month <= date_pair_q[0].first_month;
        first_day <= date_pair_q[0].first_day;
        second_year <= date_pair_q[0].second_year;
        second_month <= date_pair_q[0].second_month;
        second_day <= date_pair_q[0].second_day;
        in_valid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    req_accepted <= in_valid && in_ready_o;
    if (in_valid && in_ready_o) begin
      day_count_q.push_back(days_between(date_pair_q[0]));
      void'(date_pair_q.pop_front());
      requests_taken++;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && results_seen >= 30) begin
      out_ready <= 1'b0;
      rx_hold_left <= RxHoldCycles;
      rx_hold_done <= 1'b1;
    end else begin
      out_ready <= (results_seen >= 60 && results_seen < 85) ||
                   ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (day_count_q.size() == 0) begin
        $display("%0t: day_count %0d with no request outstanding", $time, day_count_o);
        failed = 1'b1;
      end else begin
        if (day_count_o !== day_count_q[0]) begin
          $display("%0t: day_count mismatch, expected %0d, actual %0d",
                   $time, day_count_q[0], day_count_o);
          failed = 1'b1;
        end
        void'(day_count_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("calendar_days_between_core test failed");
      $finish;
    end
  end

  initial begin
    int          y1;
    int          y2;
    int unsigned pick;

    queue_dates(2024, 2, 29, 2024, 2, 29);
    queue_dates(2023, 5, 0, 2023, 5, 1);
    queue_dates(2023, 2, 63, 2023, 3, 1);
    queue_dates(2024, 2, 31, 2024, 3, 1);
    queue_dates(1900, 2, 29, 1900, 3, 1);
    queue_dates(2000, 2, 30, 2000, 3, 0);
    queue_dates(0, 2, 29, 0, 3, 1);
    queue_dates(0, 1, 0, 1, 1, 1);
    queue_dates(2021, 0, 15, 2021, 1, 15);
    queue_dates(2021, 15, 40, 2021, 12, 31);
    queue_dates(2021, 13, 31, 2022, 0, 0);
    queue_dates(16383, 15, 63, 9999, 12, 31);
    queue_dates(12000, 1, 1, 9998, 12, 31);
    queue_dates(2000, 1, 1, 1999, 12, 31);
    queue_dates(1999, 12, 63, 2000, 1, 0);
    queue_dates(2100, 3, 1, 2100, 2, 63);
    queue_dates(9, 12, 63, 0, 0, 0);
    queue_dates(1600, 1, 1, 2000, 1, 1);
    queue_dates(8191, 7, 32, 8192, 8, 31);
    queue_dates(4, 6, 31, 3, 11, 31);

    for (int i = 0; i < RandomRequests; i++) begin
      pick = $urandom_range(0, 9);
      y1 = (pick == 0) ? 100 * $urandom_range(0, 163) : $urandom_range(0, YearSpan);
      if (pick < 6) begin
        y2 = y1 + $urandom_range(0, 2) - 1;
      end else if (pick < 9) begin
        y2 = y1 + $urandom_range(0, 8) - 4;
      end else begin
        y2 = y1 + $urandom_range(0, 60) - 30;
      end
      if (y2 < 0) y2 = 0;
      if (y2 > YearSpan) y2 = YearSpan;
      queue_dates(y1, $urandom_range(0, 15), $urandom_range(0, 63),
                  y2, $urandom_range(0, 15), $urandom_range(0, 63),
                  i == 0 || i == 70);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    while (date_pair_q.size() != 0 || day_count_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (!failed) begin
      $display("calendar_days_between_core test passed");
    end else begin
      $display("calendar_days_between_core test failed");
    end
    $finish;
  end

endmodule
